// ===== src/sdpc_pkg.sv =====
// Shared types and constants for the signal detector with pre-trigger capture.
`timescale 1ns / 1ps
`default_nettype none

package sdpc_pkg;

    // Default structural parameters.
    localparam int RING_DEPTH_DEF  = 256;
    localparam int BATCH_LEN_DEF   = 32;
    localparam int SAMPLE_BITS_DEF = 12;

    // Configuration register widths and reset values.
    localparam int THRESH_W   = 12;
    localparam int BATCHES_W  = 8;
    localparam int LIMIT_W    = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [THRESH_W-1:0]  THRESH_DEFAULT  = THRESH_W'(600);
    localparam logic [BATCHES_W-1:0] BATCHES_DEFAULT = BATCHES_W'(2);
    localparam logic [BATCHES_W-1:0] RUN_MAX         = '1;

    // Result queue between the front and back parts.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_READ   = 2'd2,
        KIND_REARM  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_NONE     = 2'd0,
        STATUS_DETECTED = 2'd1,
        STATUS_TIMEOUT  = 2'd2,
        STATUS_READ     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PHASE_LISTEN   = 2'd0,
        PHASE_DETECTED = 2'd1,
        PHASE_TIMEDOUT = 2'd2
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_BATCHES   = 2'd1,
        REG_TIMEOUT   = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/sdpc_front.sv =====
// Front part: accepts transactions, runs the detector state and owns the capture ring.
`timescale 1ns / 1ps
`default_nettype none

module sdpc_front #(
    parameter int RING_DEPTH  = sdpc_pkg::RING_DEPTH_DEF,
    parameter int BATCH_LEN   = sdpc_pkg::BATCH_LEN_DEF,
    parameter int SAMPLE_BITS = sdpc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    in_valid,
    output logic                                         in_ready,
    input  wire sdpc_pkg::kind_t                         in_kind,
    input  wire logic [SAMPLE_BITS-1:0]                  in_sample,
    input  wire logic [$clog2(RING_DEPTH)-1:0]           in_index,
    input  wire logic                                    cfg_wr_en,
    input  wire logic [sdpc_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  wire logic [sdpc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  wire logic [sdpc_pkg::Q_CNT_W-1:0]            q_count,
    output logic                                         push_valid,
    output sdpc_pkg::status_t                            push_status,
    output logic [$clog2(RING_DEPTH+1)-1:0]              push_count,
    output logic [SAMPLE_BITS-1:0]                       push_value
);
    import sdpc_pkg::*;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int BCNT_W = (BATCH_LEN > 2) ? $clog2(BATCH_LEN) : 1;
    localparam int P2P_W  = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
    localparam int CR_W   = Q_CNT_W + 1;

    // Configuration registers.
    logic [THRESH_W-1:0]  thresh_reg;
    logic [BATCHES_W-1:0] batches_reg;
    logic [LIMIT_W-1:0]   limit_reg;

    // Detector state.
    phase_t               phase_reg, phase_next;
    logic [IDX_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [SAMPLE_BITS-1:0] bmin_reg, bmin_next;
    logic [SAMPLE_BITS-1:0] bmax_reg, bmax_next;
    logic [BCNT_W-1:0]    bcnt_reg, bcnt_next;
    logic [BATCHES_W-1:0] run_reg, run_next;
    logic [LIMIT_W-1:0]   ticks_reg, ticks_next;
    logic [CNT_W-1:0]     frozen_reg, frozen_next;

    // Ring memory and its registered read port.
    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    // Result stage feeding the queue.
    logic      st1_valid_reg;
    status_t   st1_status_reg;
    logic [CNT_W-1:0] st1_count_reg;
    logic      st1_use_mem_reg;

    logic             accept;
    logic             is_listen;
    logic [SAMPLE_BITS-1:0] min_new, max_new, p2p;
    logic             batch_end;
    logic             qualify;
    logic [BATCHES_W-1:0] run_upd;
    logic [CNT_W-1:0] fill_upd;
    logic             detect_hit;
    logic [LIMIT_W-1:0] ticks_upd;
    logic             timeout_hit;
    logic             mem_we;
    logic [IDX_W:0]   rd_sum;
    logic [IDX_W-1:0] rd_pos;
    logic             rd_in_range;
    status_t          status_c;

    assign in_ready = (CR_W'(q_count) + CR_W'(st1_valid_reg)) < CR_W'(Q_DEPTH);
    assign accept   = in_valid && in_ready;
    assign is_listen = (phase_reg == PHASE_LISTEN);

    // Batch tracking for a sample.
    assign min_new   = (in_sample < bmin_reg) ? in_sample : bmin_reg;
    assign max_new   = (in_sample > bmax_reg) ? in_sample : bmax_reg;
    assign p2p       = max_new - min_new;
    assign batch_end = (bcnt_reg == BCNT_W'(BATCH_LEN - 1));
    assign qualify   = (max_new >= min_new) && (P2P_W'(p2p) >= P2P_W'(thresh_reg));
    assign run_upd   = qualify ? ((run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1) : '0;
    assign fill_upd  = (fill_reg == CNT_W'(RING_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    assign detect_hit = batch_end && (run_upd != '0) && (run_upd >= batches_reg);

    // Tick counting, saturating at all ones.
    assign ticks_upd   = (&ticks_reg) ? ticks_reg : ticks_reg + 1'b1;
    assign timeout_hit = (limit_reg != '0) && (ticks_upd >= limit_reg);

    // Oldest-first read address: a full ring starts at the write pointer.
    assign rd_sum      = {1'b0, wp_reg} + {1'b0, in_index};
    assign rd_in_range = CNT_W'(in_index) < frozen_reg;
    always_comb begin
        if (frozen_reg >= CNT_W'(RING_DEPTH)) begin
            if (rd_sum >= (IDX_W + 1)'(RING_DEPTH)) begin
                rd_pos = IDX_W'(rd_sum - (IDX_W + 1)'(RING_DEPTH));
            end else begin
                rd_pos = IDX_W'(rd_sum);
            end
        end else begin
            rd_pos = in_index;
        end
    end

    assign mem_we = accept && (in_kind == KIND_SAMPLE) && is_listen;

    // Phase transitions.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            case (in_kind)
                KIND_SAMPLE: begin
                    if (is_listen && detect_hit) begin
                        phase_next = PHASE_DETECTED;
                    end
                end
                KIND_TICK: begin
                    if (is_listen && timeout_hit) begin
                        phase_next = PHASE_TIMEDOUT;
                    end
                end
                KIND_REARM: begin
                    phase_next = PHASE_LISTEN;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Datapath state and result status.
    always_comb begin
        wp_next     = wp_reg;
        fill_next   = fill_reg;
        bmin_next   = bmin_reg;
        bmax_next   = bmax_reg;
        bcnt_next   = bcnt_reg;
        run_next    = run_reg;
        ticks_next  = ticks_reg;
        frozen_next = frozen_reg;
        status_c    = STATUS_NONE;
        if (accept) begin
            case (in_kind)
                KIND_SAMPLE: begin
                    if (is_listen) begin
                        wp_next   = (wp_reg == IDX_W'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                        fill_next = fill_upd;
                        if (batch_end) begin
                            bmin_next = '1;
                            bmax_next = '0;
                            bcnt_next = '0;
                            run_next  = run_upd;
                            if (detect_hit) begin
                                frozen_next = fill_upd;
                                status_c    = STATUS_DETECTED;
                            end
                        end else begin
                            bmin_next = min_new;
                            bmax_next = max_new;
                            bcnt_next = bcnt_reg + 1'b1;
                        end
                    end
                end
                KIND_TICK: begin
                    if (is_listen) begin
                        ticks_next = ticks_upd;
                        if (timeout_hit) begin
                            frozen_next = '0;
                            status_c    = STATUS_TIMEOUT;
                        end
                    end
                end
                KIND_READ: begin
                    status_c = STATUS_READ;
                end
                KIND_REARM: begin
                    wp_next     = '0;
                    fill_next   = '0;
                    bmin_next   = '1;
                    bmax_next   = '0;
                    bcnt_next   = '0;
                    run_next    = '0;
                    ticks_next  = '0;
                    frozen_next = '0;
                end
                default: begin
                    status_c = STATUS_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg  <= THRESH_DEFAULT;
            batches_reg <= BATCHES_DEFAULT;
            limit_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_THRESHOLD: begin
                    thresh_reg <= (cfg_wdata[THRESH_W-1:0] == '0) ?
                                  THRESH_DEFAULT : cfg_wdata[THRESH_W-1:0];
                end
                REG_BATCHES: begin
                    batches_reg <= (cfg_wdata[BATCHES_W-1:0] == '0) ?
                                   BATCHES_DEFAULT : cfg_wdata[BATCHES_W-1:0];
                end
                REG_TIMEOUT: begin
                    limit_reg <= cfg_wdata[LIMIT_W-1:0];
                end
                default: begin
                    limit_reg <= limit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_LISTEN;
            wp_reg        <= '0;
            fill_reg      <= '0;
            bmin_reg      <= '1;
            bmax_reg      <= '0;
            bcnt_reg      <= '0;
            run_reg       <= '0;
            ticks_reg     <= '0;
            frozen_reg    <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            bmin_reg      <= bmin_next;
            bmax_reg      <= bmax_next;
            bcnt_reg      <= bcnt_next;
            run_reg       <= run_next;
            ticks_reg     <= ticks_next;
            frozen_reg    <= frozen_next;
            st1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_status_reg  <= status_c;
            st1_count_reg   <= frozen_next;
            st1_use_mem_reg <= (in_kind == KIND_READ) && rd_in_range;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring_mem[wp_reg] <= in_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (in_kind == KIND_READ)) begin
            rd_data_reg <= ring_mem[rd_pos];
        end
    end

    assign push_valid  = st1_valid_reg;
    assign push_status = st1_status_reg;
    assign push_count  = st1_count_reg;
    assign push_value  = st1_use_mem_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== src/sdpc_back.sv =====
// Back part: result queue and the registered output stage.
`timescale 1ns / 1ps
`default_nettype none

module sdpc_back #(
    parameter int RING_DEPTH  = sdpc_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = sdpc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               push_valid,
    input  wire sdpc_pkg::status_t                  push_status,
    input  wire logic [$clog2(RING_DEPTH+1)-1:0]    push_count,
    input  wire logic [SAMPLE_BITS-1:0]             push_value,
    output logic [sdpc_pkg::Q_CNT_W-1:0]            q_count,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output sdpc_pkg::status_t                       out_status,
    output logic [$clog2(RING_DEPTH+1)-1:0]         out_count,
    output logic [SAMPLE_BITS-1:0]                  out_value
);
    import sdpc_pkg::*;

    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    status_t                q_status_reg [Q_DEPTH];
    logic [CNT_W-1:0]       q_cnt_reg    [Q_DEPTH];
    logic [SAMPLE_BITS-1:0] q_value_reg  [Q_DEPTH];
    logic [Q_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]     count_reg, count_next;

    logic                   m_valid_reg;
    status_t                m_status_reg;
    logic [CNT_W-1:0]       m_count_reg;
    logic [SAMPLE_BITS-1:0] m_value_reg;

    logic out_load;
    logic pop;

    // The output register may take a new entry when empty or being drained.
    assign out_load   = !m_valid_reg || out_ready;
    assign pop        = out_load && (count_reg != '0);
    assign count_next = count_reg + Q_CNT_W'(push_valid) - Q_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push_valid) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg  <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
                m_valid_reg <= 1'b1;
            end else if (out_load) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            q_status_reg[wr_ptr_reg] <= push_status;
            q_cnt_reg[wr_ptr_reg]    <= push_count;
            q_value_reg[wr_ptr_reg]  <= push_value;
        end
        if (pop) begin
            m_status_reg <= q_status_reg[rd_ptr_reg];
            m_count_reg  <= q_cnt_reg[rd_ptr_reg];
            m_value_reg  <= q_value_reg[rd_ptr_reg];
        end
    end

    assign q_count    = count_reg;
    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_count  = m_count_reg;
    assign out_value  = m_value_reg;

endmodule

`default_nettype wire

// ===== src/signal_detect_pretrigger_capture.sv =====
// Top level of the peak-to-peak signal detector with pre-trigger capture ring.
`timescale 1ns / 1ps
`default_nettype none

// Every input transaction carries a kind in s_tuser: an ADC sample, a millisecond
// tick, a read of the captured pre-trigger store, or a re-arm command. Each one
// produces exactly one result transaction, in order. While listening, samples are
// written into a ring of RING_DEPTH entries and grouped into batches of BATCH_LEN;
// a batch whose peak-to-peak reaches the threshold register extends a run, any other
// batch ends it, and a run of needed_batches batches reports detection and freezes
// the ring. Ticks count towards timeout_limit (zero means no timeout). Reads return
// the frozen samples oldest first and zero beyond the captured count. The block
// takes one transaction per clock cycle while the result queue has room: the front
// part updates the detector state and registers the result, together with any ring
// read, as it accepts the transaction; the result passes on through a four-entry
// result queue into the registered output. The input keeps accepting while results
// wait, until the queue is full. The user must write the configuration registers
// through cfg_wr_en, cfg_addr and cfg_wdata only while no transaction is in
// flight; the block does not enforce this. A zero written to the threshold or the
// batch count selects its default. The ring needs no clearing after reset.
module signal_detect_pretrigger_capture #(
    parameter int RING_DEPTH  = sdpc_pkg::RING_DEPTH_DEF,
    parameter int BATCH_LEN   = sdpc_pkg::BATCH_LEN_DEF,
    parameter int SAMPLE_BITS = sdpc_pkg::SAMPLE_BITS_DEF,
    localparam int S_DATA_W = ((SAMPLE_BITS + $clog2(RING_DEPTH) + 7) / 8) * 8,
    localparam int M_DATA_W = ((SAMPLE_BITS + $clog2(RING_DEPTH + 1) + 7) / 8) * 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // Fields from bit 0: sample, read_index; zero padded to whole bytes.
    input  wire logic [S_DATA_W-1:0]               s_tdata,
    // Fields from bit 0: kind.
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // Fields from bit 0: captured_count, read_value; zero padded to whole bytes.
    output logic [M_DATA_W-1:0]                    m_tdata,
    // Fields from bit 0: status.
    output logic [1:0]                             m_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sdpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [sdpc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import sdpc_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);

    // Handshake and payload between the front part and the result queue.
    logic                   push_valid;
    status_t                push_status;
    logic [CNT_W-1:0]       push_count;
    logic [SAMPLE_BITS-1:0] push_value;
    logic [Q_CNT_W-1:0]     q_count;

    // Registered output stage.
    status_t                out_status;
    logic [CNT_W-1:0]       out_count;
    logic [SAMPLE_BITS-1:0] out_value;

    // The front part classifies each transaction, updates the detector and
    // reserves a queue slot for its result before it accepts it.
    sdpc_front #(
        .RING_DEPTH  (RING_DEPTH),
        .BATCH_LEN   (BATCH_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (kind_t'(s_tuser)),
        .in_sample   (s_tdata[SAMPLE_BITS-1:0]),
        .in_index    (s_tdata[SAMPLE_BITS +: IDX_W]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .q_count     (q_count),
        .push_valid  (push_valid),
        .push_status (push_status),
        .push_count  (push_count),
        .push_value  (push_value)
    );

    // The back part queues results and drives the output register, so a
    // stalled consumer does not hold up the front part until the queue fills.
    sdpc_back #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_valid  (push_valid),
        .push_status (push_status),
        .push_count  (push_count),
        .push_value  (push_value),
        .q_count     (q_count),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_count   (out_count),
        .out_value   (out_value)
    );

    assign m_tuser = out_status;
    assign m_tdata = M_DATA_W'({out_value, out_count});

    // The credit check must keep the queue from ever overflowing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    // A detection always follows at least one stored sample.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_DETECTED)) |-> (out_count != '0))
        else $error("detection reported with an empty capture");

    // A timeout releases the capture.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_TIMEOUT)) |-> (out_count == '0)
            && (out_value == '0))
        else $error("timeout result carries capture data");

endmodule

`default_nettype wire
